@@ design/spt_pkg.sv @@
// shared types and constants for the sync pulse train generator
package spt_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SYNC_ON   = 3'd0,
    REG_FIRST_ON  = 3'd1,
    REG_ON_STEP   = 3'd2,
    REG_OFF       = 3'd3,
    REG_FINAL_OFF = 3'd4,
    REG_PULSE_CNT = 3'd5,
    REG_DROPPED   = 3'd6
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;

  // reset values of the configuration registers
  localparam int SYNC_ON_RST   = 50;
  localparam int FIRST_ON_RST  = 400;
  localparam int ON_STEP_RST   = 50;
  localparam int OFF_RST       = 900;
  localparam int FINAL_OFF_RST = 6000;
  localparam int PULSE_CNT_RST = 16;
  localparam int DROPPED_RST   = 3;

  typedef enum logic [3:0] {
    PH_SYNC  = 4'b0001,
    PH_ON    = 4'b0010,
    PH_OFF   = 4'b0100,
    PH_FINAL = 4'b1000
  } phase_t;

  // button flags after this item's edge update
  typedef struct packed {
    logic enable;
    logic normal;
  } flags_t;

endpackage

@@ design/spt_ifs.sv @@
// valid/ready channels for button items and line-level results

interface spt_in_if;
  logic valid;
  logic ready;
  logic enable_button;
  logic select_button;

  modport source (output valid, output enable_button, output select_button, input ready);
  modport sink (input valid, input enable_button, input select_button, output ready);
endinterface

interface spt_out_if;
  logic valid;
  logic ready;
  logic data_level;
  logic sync_level;
  logic enabled;
  logic normal_mode;

  modport source (output valid, output data_level, output sync_level, output enabled,
                  output normal_mode, input ready);
  modport sink (input valid, input data_level, input sync_level, input enabled,
                input normal_mode, output ready);
endinterface

@@ design/spt_cfg_regs.sv @@
// configuration register bank with write port
module spt_cfg_regs #(
  parameter int TIME_WIDTH  = 24,
  parameter int INDEX_WIDTH = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [spt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [TIME_WIDTH-1:0]         cfg_data,
  output logic [TIME_WIDTH-1:0]         sync_on,
  output logic [TIME_WIDTH-1:0]         first_on,
  output logic [TIME_WIDTH-1:0]         on_step,
  output logic [TIME_WIDTH-1:0]         off_len,
  output logic [TIME_WIDTH-1:0]         final_off,
  output logic [INDEX_WIDTH-1:0]        pulse_cnt,
  output logic [INDEX_WIDTH-1:0]        dropped
);

  logic [TIME_WIDTH-1:0]  sync_on_r, first_on_r, on_step_r, off_r, final_off_r;
  logic [INDEX_WIDTH-1:0] pulse_cnt_r, dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_on_r   <= TIME_WIDTH'(spt_pkg::SYNC_ON_RST);
      first_on_r  <= TIME_WIDTH'(spt_pkg::FIRST_ON_RST);
      on_step_r   <= TIME_WIDTH'(spt_pkg::ON_STEP_RST);
      off_r       <= TIME_WIDTH'(spt_pkg::OFF_RST);
      final_off_r <= TIME_WIDTH'(spt_pkg::FINAL_OFF_RST);
      pulse_cnt_r <= INDEX_WIDTH'(spt_pkg::PULSE_CNT_RST);
      dropped_r   <= INDEX_WIDTH'(spt_pkg::DROPPED_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        spt_pkg::REG_SYNC_ON:   sync_on_r   <= cfg_data;
        spt_pkg::REG_FIRST_ON:  first_on_r  <= cfg_data;
        spt_pkg::REG_ON_STEP:   on_step_r   <= cfg_data;
        spt_pkg::REG_OFF:       off_r       <= cfg_data;
        spt_pkg::REG_FINAL_OFF: final_off_r <= cfg_data;
        spt_pkg::REG_PULSE_CNT: pulse_cnt_r <= cfg_data[INDEX_WIDTH-1:0];
        spt_pkg::REG_DROPPED:   dropped_r   <= cfg_data[INDEX_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign sync_on   = sync_on_r;
  assign first_on  = first_on_r;
  assign on_step   = on_step_r;
  assign off_len   = off_r;
  assign final_off = final_off_r;
  assign pulse_cnt = pulse_cnt_r;
  assign dropped   = dropped_r;

endmodule

@@ design/spt_flags.sv @@
// button rising-edge detection and enable / mode flags
module spt_flags (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            enable_button,
  input  logic            select_button,
  output spt_pkg::flags_t flags
);

  logic enable_prev_r, select_prev_r;
  logic enable_r, normal_r;
  logic enable_nxt, normal_nxt;

  assign enable_nxt = enable_r ^ (enable_button & ~enable_prev_r);
  assign normal_nxt = normal_r ^ (select_button & ~select_prev_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_prev_r <= 1'b0;
      select_prev_r <= 1'b0;
      enable_r      <= 1'b0;
      normal_r      <= 1'b1;
    end else if (step) begin
      enable_prev_r <= enable_button;
      select_prev_r <= select_button;
      enable_r      <= enable_nxt;
      normal_r      <= normal_nxt;
    end
  end

  assign flags.enable = enable_nxt;
  assign flags.normal = normal_nxt;

endmodule

@@ design/spt_seq.sv @@
// frame sequencer: sync pulse, growing data pulses, off gaps and final gap
module spt_seq #(
  parameter int TIME_WIDTH  = 24,
  parameter int INDEX_WIDTH = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  spt_pkg::flags_t        flags,
  input  logic [TIME_WIDTH-1:0]  sync_on,
  input  logic [TIME_WIDTH-1:0]  first_on,
  input  logic [TIME_WIDTH-1:0]  on_step,
  input  logic [TIME_WIDTH-1:0]  off_len,
  input  logic [TIME_WIDTH-1:0]  final_off,
  input  logic [INDEX_WIDTH-1:0] pulse_cnt,
  input  logic [INDEX_WIDTH-1:0] dropped,
  output logic                   data_level,
  output logic                   sync_level
);

  spt_pkg::phase_t        phase_r, phase_nxt, phase_cur;
  logic [TIME_WIDTH-1:0]  ticks_r, ticks_nxt, ticks_inc;
  logic [TIME_WIDTH-1:0]  width_r, width_nxt, width_sat;
  logic [TIME_WIDTH:0]    width_sum;
  logic [INDEX_WIDTH-1:0] idx_r, idx_nxt;
  logic [INDEX_WIDTH:0]   idx_plus_drop;
  logic                   drive_r, drive_nxt, drive_cur;
  logic                   skip;
  logic [TIME_WIDTH-1:0]  len, len_eff;
  logic                   done;

  assign idx_plus_drop = {1'b0, idx_r} + {1'b0, dropped};
  assign skip = (idx_r > pulse_cnt) ||
                (!flags.normal && (idx_plus_drop > {1'b0, pulse_cnt}));

  assign width_sum = {1'b0, width_r} + {1'b0, on_step};
  assign width_sat = width_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : width_sum[TIME_WIDTH-1:0];

  // flags are sampled on the first tick of a data pulse
  always_comb begin
    phase_cur = phase_r;
    drive_cur = drive_r;
    if (phase_r == spt_pkg::PH_ON && ticks_r == '0) begin
      if (skip) begin
        phase_cur = spt_pkg::PH_FINAL;
        drive_cur = 1'b0;
      end else begin
        drive_cur = flags.enable;
      end
    end
  end

  assign data_level = (phase_cur == spt_pkg::PH_ON) && drive_cur;
  assign sync_level = (phase_cur == spt_pkg::PH_SYNC);

  always_comb begin
    case (phase_cur)
      spt_pkg::PH_SYNC: len = sync_on;
      spt_pkg::PH_ON:   len = width_r;
      spt_pkg::PH_OFF:  len = off_len;
      default:          len = final_off;
    endcase
  end

  assign len_eff   = (len == '0) ? TIME_WIDTH'(1) : len;
  assign ticks_inc = ticks_r + TIME_WIDTH'(1);
  assign done      = (ticks_inc == '0) || (ticks_inc >= len_eff);

  always_comb begin
    phase_nxt = phase_cur;
    ticks_nxt = ticks_inc;
    drive_nxt = drive_cur;
    idx_nxt   = idx_r;
    width_nxt = width_r;
    if (done) begin
      ticks_nxt = '0;
      case (phase_cur)
        spt_pkg::PH_SYNC: phase_nxt = spt_pkg::PH_ON;
        spt_pkg::PH_ON: begin
          phase_nxt = spt_pkg::PH_OFF;
          drive_nxt = 1'b0;
        end
        spt_pkg::PH_OFF: begin
          if (idx_r >= pulse_cnt) begin
            phase_nxt = spt_pkg::PH_FINAL;
          end else begin
            phase_nxt = spt_pkg::PH_ON;
            idx_nxt   = idx_r + INDEX_WIDTH'(1);
            width_nxt = width_sat;
          end
        end
        default: begin
          // new frame
          phase_nxt = spt_pkg::PH_SYNC;
          idx_nxt   = INDEX_WIDTH'(1);
          width_nxt = first_on;
          drive_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= spt_pkg::PH_SYNC;
      ticks_r <= '0;
      width_r <= TIME_WIDTH'(spt_pkg::FIRST_ON_RST);
      idx_r   <= INDEX_WIDTH'(1);
      drive_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      width_r <= width_nxt;
      idx_r   <= idx_nxt;
      drive_r <= drive_nxt;
    end
  end

  a_lines_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(data_level && sync_level))
    else $error("data and sync lines high together");

  a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != '0)
    else $error("pulse index reached zero");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && done && phase_cur == spt_pkg::PH_FINAL |=>
      phase_r == spt_pkg::PH_SYNC && idx_r == INDEX_WIDTH'(1) && ticks_r == '0)
    else $error("frame did not restart after final gap");

endmodule

@@ design/sync_pulse_train_generator_core.sv @@
// top level of the sync pulse train generator: channels, pipeline and config port
//
// Each input item is one time tick carrying the two button levels; each tick
// yields exactly one result item with the data line, sync line and both flags.
// An item is taken every cycle as long as the result side keeps up: the tick
// is held in the input register, the sequencer (one 24-bit increment and
// compare on the phase counter) updates while the tick is held there, and the
// result is held in the output register, so throughput is one item per
// cycle. Configuration registers are written through cfg_we, cfg_index and
// cfg_data and take effect on the next tick; writes to an index beyond the
// register list are dropped.
module sync_pulse_train_generator_core #(
  parameter int TIME_WIDTH  = 24,
  parameter int INDEX_WIDTH = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  spt_in_if.sink                          in_ch,
  spt_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [spt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [TIME_WIDTH-1:0]           cfg_data
);

  logic                   s1_valid_r;
  logic                   s1_enable_r, s1_select_r;
  logic                   out_valid_r;
  logic                   out_data_r, out_sync_r, out_enabled_r, out_normal_r;
  logic                   advance, step;
  spt_pkg::flags_t        flags;
  logic                   data_level, sync_level;
  logic [TIME_WIDTH-1:0]  sync_on, first_on, on_step, off_len, final_off;
  logic [INDEX_WIDTH-1:0] pulse_cnt, dropped;

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_enable_r <= in_ch.enable_button;
      s1_select_r <= in_ch.select_button;
    end
  end

  spt_cfg_regs #(
    .TIME_WIDTH (TIME_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sync_on  (sync_on),
    .first_on (first_on),
    .on_step  (on_step),
    .off_len  (off_len),
    .final_off(final_off),
    .pulse_cnt(pulse_cnt),
    .dropped  (dropped)
  );

  spt_flags u_flags (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .enable_button(s1_enable_r),
    .select_button(s1_select_r),
    .flags        (flags)
  );

  spt_seq #(
    .TIME_WIDTH (TIME_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .flags     (flags),
    .sync_on   (sync_on),
    .first_on  (first_on),
    .on_step   (on_step),
    .off_len   (off_len),
    .final_off (final_off),
    .pulse_cnt (pulse_cnt),
    .dropped   (dropped),
    .data_level(data_level),
    .sync_level(sync_level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r    <= data_level;
      out_sync_r    <= sync_level;
      out_enabled_r <= flags.enable;
      out_normal_r  <= flags.normal;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_level  = out_data_r;
  assign out_ch.sync_level  = out_sync_r;
  assign out_ch.enabled     = out_enabled_r;
  assign out_ch.normal_mode = out_normal_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed item did not reach the result register");

endmodule

@@ dv/tb_sync_pulse_train_generator_core.sv @@
// testbench for the sync pulse train generator core: directed table, random phases, line checks
module tb_sync_pulse_train_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_W = 24;
  localparam int IDX_W = 5;
  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_LIMIT = 2000;
  localparam int SQUEEZE_CYCLES = 60;
  localparam int IDLE_PCT = 34;
  localparam logic [spt_pkg::CFG_INDEX_W-1:0] REG_NONE = 3'd7;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // line levels of one tick, in port order
  typedef struct packed {
    logic data_level;
    logic sync_level;
    logic enabled;
    logic normal_mode;
  } lines_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [spt_pkg::CFG_INDEX_W-1:0] reg_sel;
    logic [TIME_W-1:0]               value;
    logic                            eb;
    logic                            sb;
    logic                            typed;
    lines_t                          lines;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [spt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [TIME_W-1:0] cfg_data;

  spt_in_if in_ch();
  spt_out_if out_ch();

  sync_pulse_train_generator_core #(
    .TIME_WIDTH (TIME_W),
    .INDEX_WIDTH(IDX_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // register copies
  logic [TIME_W-1:0] sync_on_len, first_on_len, on_step_len, off_len, final_off_len;
  logic [IDX_W-1:0] pulse_total, drop_total;

  // frame state
  spt_pkg::phase_t cur_phase;
  logic [IDX_W-1:0] pulse_no;
  logic [TIME_W-1:0] tick_cnt, high_len;
  logic enable_flag, normal_flag, eb_prev, sb_prev, data_drive;

  lines_t pending_lines[$];
  plan_row_t plan[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  logic calm = 1'b0;
  logic squeeze_armed = 1'b0;

  function automatic void restart_frame();
    cur_phase = spt_pkg::PH_SYNC;
    pulse_no = IDX_W'(1);
    high_len = first_on_len;
    tick_cnt = '0;
    data_drive = 1'b0;
  endfunction

  function automatic logic [TIME_W-1:0] phase_span();
    logic [TIME_W-1:0] len;
    case (cur_phase)
      spt_pkg::PH_SYNC: len = sync_on_len;
      spt_pkg::PH_ON:   len = high_len;
      spt_pkg::PH_OFF:  len = off_len;
      default:          len = final_off_len;
    endcase
    return (len == '0) ? TIME_W'(1) : len;
  endfunction

  // advances the frame by one tick and returns the line levels it shows
  function automatic lines_t next_lines(logic eb, logic sb);
    lines_t r;
    logic [TIME_W:0] grown;
    if (eb && !eb_prev) enable_flag = !enable_flag;
    if (sb && !sb_prev) normal_flag = !normal_flag;
    eb_prev = eb;
    sb_prev = sb;
    if (cur_phase == spt_pkg::PH_ON && tick_cnt == '0) begin
      if (pulse_no > pulse_total ||
          (!normal_flag && int'(pulse_no) + int'(drop_total) > int'(pulse_total))) begin
        cur_phase = spt_pkg::PH_FINAL;
        data_drive = 1'b0;
      end else begin
        data_drive = enable_flag;
      end
    end
    r.data_level = (cur_phase == spt_pkg::PH_ON) && data_drive;
    r.sync_level = (cur_phase == spt_pkg::PH_SYNC);
    r.enabled = enable_flag;
    r.normal_mode = normal_flag;
    tick_cnt = tick_cnt + TIME_W'(1);
    if (tick_cnt == '0 || tick_cnt >= phase_span()) begin
      tick_cnt = '0;
      case (cur_phase)
        spt_pkg::PH_SYNC: cur_phase = spt_pkg::PH_ON;
        spt_pkg::PH_ON: begin
          cur_phase = spt_pkg::PH_OFF;
          data_drive = 1'b0;
        end
        spt_pkg::PH_OFF: begin
          if (pulse_no >= pulse_total) begin
            cur_phase = spt_pkg::PH_FINAL;
          end else begin
            grown = {1'b0, high_len} + {1'b0, on_step_len};
            pulse_no = pulse_no + IDX_W'(1);
            high_len = grown[TIME_W] ? TIME_MAX : grown[TIME_W-1:0];
            cur_phase = spt_pkg::PH_ON;
          end
        end
        default: restart_frame();
      endcase
    end
    return r;
  endfunction

  function automatic plan_row_t tick_row(logic eb, logic sb);
    plan_row_t row;
    row = '{ROW_TICK, '0, '0, eb, sb, 1'b0, '0};
    return row;
  endfunction

  function automatic plan_row_t seen_row(logic eb, logic sb, lines_t lines);
    plan_row_t row;
    row = '{ROW_TICK, '0, '0, eb, sb, 1'b1, lines};
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [spt_pkg::CFG_INDEX_W-1:0] sel,
                                        logic [TIME_W-1:0] value);
    plan_row_t row;
    row = '{ROW_WRITE, sel, value, 1'b0, 1'b0, 1'b0, '0};
    return row;
  endfunction

  function automatic logic [TIME_W-1:0] pick_span(bit wide);
    if (!wide) return TIME_W'($urandom_range(0, 4));
    case ($urandom_range(9))
      0: return '0;
      7: return TIME_W'($urandom_range(7, 40));
      8: return TIME_W'($urandom_range(41, 200));
      9: return ($urandom_range(1) == 0) ? TIME_MAX : TIME_W'($urandom_range(0, 3));
      default: return TIME_W'($urandom_range(1, 6));
    endcase
  endfunction

  // count fields carry random upper bits that the block must drop
  function automatic logic [TIME_W-1:0] pick_count();
    logic [TIME_W-1:0] junk;
    logic [IDX_W-1:0] cnt;
    junk = TIME_W'($urandom()) & ~TIME_W'(32'h1f);
    cnt = ($urandom_range(2) != 0) ? IDX_W'($urandom_range(0, 6))
                                   : IDX_W'($urandom_range(0, 31));
    return junk | TIME_W'(cnt);
  endfunction

  task automatic check_bit(string field, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      mismatches++;
    end
  endtask

  task automatic send_tick(logic eb, logic sb, logic typed, lines_t typed_lines);
    lines_t want;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.enable_button <= eb;
    in_ch.select_button <= sb;
    do @(posedge clk); while (!in_ch.ready);
    want = next_lines(eb, sb);
    pending_lines.push_back(typed ? typed_lines : want);
  endtask

  // wait until every tick has come back and the pipeline is empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [spt_pkg::CFG_INDEX_W-1:0] reg_sel, logic [TIME_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (reg_sel)
      spt_pkg::REG_SYNC_ON:   sync_on_len = value;
      spt_pkg::REG_FIRST_ON:  first_on_len = value;
      spt_pkg::REG_ON_STEP:   on_step_len = value;
      spt_pkg::REG_OFF:       off_len = value;
      spt_pkg::REG_FINAL_OFF: final_off_len = value;
      spt_pkg::REG_PULSE_CNT: pulse_total = value[IDX_W-1:0];
      spt_pkg::REG_DROPPED:   drop_total = value[IDX_W-1:0];
      default: ;
    endcase
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    bit squeeze_done;
    squeeze_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_armed && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : line_check
    lines_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.data_level, out_ch.sync_level, out_ch.enabled, out_ch.normal_mode};
      if (pending_lines.size() == 0) begin
        $error("result item with nothing expected");
        mismatches++;
      end else begin
        want = pending_lines.pop_front();
        check_bit("data_level", want.data_level, got.data_level);
        check_bit("sync_level", want.sync_level, got.sync_level);
        check_bit("enabled", want.enabled, got.enabled);
        check_bit("normal_mode", want.normal_mode, got.normal_mode);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int sent;
    int span;
    int flip_pct;
    int phase_no;
    int guard;
    logic eb_lvl, sb_lvl;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.enable_button = 1'b0;
    in_ch.select_button = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    sync_on_len = TIME_W'(spt_pkg::SYNC_ON_RST);
    first_on_len = TIME_W'(spt_pkg::FIRST_ON_RST);
    on_step_len = TIME_W'(spt_pkg::ON_STEP_RST);
    off_len = TIME_W'(spt_pkg::OFF_RST);
    final_off_len = TIME_W'(spt_pkg::FINAL_OFF_RST);
    pulse_total = IDX_W'(spt_pkg::PULSE_CNT_RST);
    drop_total = IDX_W'(spt_pkg::DROPPED_RST);
    enable_flag = 1'b0;
    normal_flag = 1'b1;
    eb_prev = 1'b0;
    sb_prev = 1'b0;
    restart_frame();

    // reset timing: still in the sync pulse, flags follow the button edges
    plan.push_back(seen_row(1'b0, 1'b0, 4'b0101));
    plan.push_back(seen_row(1'b1, 1'b0, 4'b0111));
    plan.push_back(seen_row(1'b1, 1'b1, 4'b0110));
    plan.push_back(seen_row(1'b0, 1'b1, 4'b0110));
    plan.push_back(seen_row(1'b0, 1'b0, 4'b0110));
    // zero durations mid-frame, pulse count zero through a masked write, dead index
    plan.push_back(reg_row(spt_pkg::REG_SYNC_ON, '0));
    plan.push_back(reg_row(spt_pkg::REG_FIRST_ON, '0));
    plan.push_back(reg_row(spt_pkg::REG_OFF, '0));
    plan.push_back(reg_row(spt_pkg::REG_FINAL_OFF, '0));
    plan.push_back(reg_row(spt_pkg::REG_PULSE_CNT, 24'h000020));
    plan.push_back(reg_row(REG_NONE, 24'h000005));
    plan.push_back(tick_row(1'b0, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b0));
    // alternative mode dropping every pulse
    plan.push_back(reg_row(spt_pkg::REG_PULSE_CNT, 24'd2));
    plan.push_back(reg_row(spt_pkg::REG_DROPPED, 24'd2));
    plan.push_back(tick_row(1'b0, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b0));
    // alternative mode dropping the last pulse, then normal mode and disabled output
    plan.push_back(reg_row(spt_pkg::REG_DROPPED, 24'd1));
    plan.push_back(tick_row(1'b0, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b1));
    plan.push_back(tick_row(1'b1, 1'b0));
    plan.push_back(tick_row(1'b1, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].reg_sel, plan[i].value);
      end else begin
        send_tick(plan[i].eb, plan[i].sb, plan[i].typed, plan[i].lines);
      end
    end

    sent = 0;
    phase_no = 0;
    eb_lvl = 1'b0;
    sb_lvl = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      calm = (phase_no == 0);
      if (phase_no == 1) squeeze_armed <= 1'b1;
      write_reg(spt_pkg::REG_SYNC_ON, pick_span(1'b1));
      write_reg(spt_pkg::REG_FIRST_ON, pick_span(1'b0));
      write_reg(spt_pkg::REG_ON_STEP, pick_span(1'b0));
      write_reg(spt_pkg::REG_OFF, pick_span(1'b1));
      write_reg(spt_pkg::REG_FINAL_OFF, pick_span(1'b1));
      write_reg(spt_pkg::REG_PULSE_CNT, pick_count());
      write_reg(spt_pkg::REG_DROPPED, pick_count());
      if ($urandom_range(3) == 0) write_reg(REG_NONE, TIME_W'($urandom()));
      if (phase_no == 3) begin
        write_reg(spt_pkg::REG_SYNC_ON, TIME_MAX);
        write_reg(spt_pkg::REG_PULSE_CNT, TIME_MAX);
        write_reg(spt_pkg::REG_DROPPED, TIME_MAX);
      end
      case ($urandom_range(2))
        0: flip_pct = 2;
        1: flip_pct = 12;
        default: flip_pct = 50;
      endcase
      span = calm ? 150 : $urandom_range(30, 90);
      repeat (span) begin
        if ($urandom_range(99) < flip_pct) eb_lvl = !eb_lvl;
        if ($urandom_range(99) < flip_pct) sb_lvl = !sb_lvl;
        send_tick(eb_lvl, sb_lvl, 1'b0, '0);
        sent++;
      end
      phase_no++;
    end

    // saturated high time: the next pulse grows past the counter range
    settle();
    calm = 1'b0;
    write_reg(spt_pkg::REG_SYNC_ON, '0);
    write_reg(spt_pkg::REG_OFF, '0);
    write_reg(spt_pkg::REG_FINAL_OFF, '0);
    write_reg(spt_pkg::REG_ON_STEP, TIME_MAX);
    write_reg(spt_pkg::REG_FIRST_ON, TIME_MAX);
    write_reg(spt_pkg::REG_PULSE_CNT, 24'd31);
    write_reg(spt_pkg::REG_DROPPED, '0);
    guard = 0;
    while (!(cur_phase == spt_pkg::PH_ON && high_len == TIME_MAX) && guard < 3000) begin
      send_tick(1'b0, 1'b0, 1'b0, '0);
      guard++;
    end
    repeat (20) send_tick(1'b0, 1'b0, 1'b0, '0);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
